@@ rtl/gms_pkg.sv @@
// ----------------------------------------------------------------------------
// Gantry move sequencer package
// Shared types and constants of the gantry move sequencer.
// ----------------------------------------------------------------------------
package gms_pkg;

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_STEP_HALF_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_X_SCALE          = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_SCALE          = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_TRAVEL         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL_TICKS      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_STEPS    = 3'd5;

  // Reset values of the fixed-width registers.
  localparam logic [15:0] RST_STEP_HALF_PERIOD = 16'd800;
  localparam logic [15:0] RST_Z_TRAVEL         = 16'd980;
  localparam logic [23:0] RST_DWELL_TICKS      = 24'd4000000;
  localparam logic [7:0]  RST_BACKOFF_STEPS    = 8'd5;

  // Default scales in thousandths of a step per coordinate unit.
  localparam int X_SCALE_MILLI = 1578;
  localparam int Y_SCALE_MILLI = 1239;

  // Step counts saturate at this value.
  localparam logic [15:0] STEP_MAX = 16'hFFFF;

  // Motion timing settings that do not depend on the coordinate format.
  typedef struct packed {
    logic [15:0] half_period;
    logic [15:0] z_travel;
    logic [23:0] dwell_ticks;
    logic [7:0]  backoff;
  } gms_timing_t;

  // One result item.
  typedef struct packed {
    logic x_step;
    logic x_dir;
    logic y_step;
    logic y_dir;
    logic z_step;
    logic z_dir;
    logic heater_on;
    logic busy_res;
    logic move_done;
  } gms_result_t;

endpackage

@@ rtl/gms_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// Gantry move sequencer configuration registers
// Holds the motion settings; written through a plain write port.
// ----------------------------------------------------------------------------
module gms_cfg_regs import gms_pkg::*; #(
  parameter int SCALE_FRAC_BITS = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_idx,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  output gms_timing_t                  timing,
  output logic [SCALE_FRAC_BITS+1:0]   x_scale,
  output logic [SCALE_FRAC_BITS+1:0]   y_scale
);

  localparam int SCALE_W = SCALE_FRAC_BITS + 2;
  localparam int X_SCALE_RST = (X_SCALE_MILLI * (1 << SCALE_FRAC_BITS) + 500) / 1000;
  localparam int Y_SCALE_RST = (Y_SCALE_MILLI * (1 << SCALE_FRAC_BITS) + 500) / 1000;

  gms_timing_t        timing_r;
  logic [SCALE_W-1:0] x_scale_r;
  logic [SCALE_W-1:0] y_scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timing_r.half_period <= RST_STEP_HALF_PERIOD;
      timing_r.z_travel    <= RST_Z_TRAVEL;
      timing_r.dwell_ticks <= RST_DWELL_TICKS;
      timing_r.backoff     <= RST_BACKOFF_STEPS;
      x_scale_r            <= SCALE_W'(X_SCALE_RST);
      y_scale_r            <= SCALE_W'(Y_SCALE_RST);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_STEP_HALF_PERIOD: timing_r.half_period <= cfg_wdata[15:0];
        CFG_X_SCALE:          x_scale_r            <= cfg_wdata[SCALE_W-1:0];
        CFG_Y_SCALE:          y_scale_r            <= cfg_wdata[SCALE_W-1:0];
        CFG_Z_TRAVEL:         timing_r.z_travel    <= cfg_wdata[15:0];
        CFG_DWELL_TICKS:      timing_r.dwell_ticks <= cfg_wdata[23:0];
        CFG_BACKOFF_STEPS:    timing_r.backoff     <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign timing  = timing_r;
  assign x_scale = x_scale_r;
  assign y_scale = y_scale_r;

endmodule

@@ rtl/gms_step_calc.sv @@
// ----------------------------------------------------------------------------
// Gantry move sequencer step count calculation
// Step count of one axis: |target - position| times a fixed-point scale,
// rounded half up and saturated to 16 bits.
// ----------------------------------------------------------------------------
module gms_step_calc import gms_pkg::*; #(
  parameter int COORD_BITS      = 14,
  parameter int SCALE_FRAC_BITS = 12
) (
  input  logic [COORD_BITS-1:0]        position,
  input  logic [COORD_BITS-1:0]        target,
  input  logic [SCALE_FRAC_BITS+1:0]   scale,
  output logic [15:0]                  steps
);

  localparam int PROD_W = COORD_BITS + SCALE_FRAC_BITS + 2;
  localparam int SUM_W  = PROD_W + 1;

  logic [COORD_BITS-1:0] delta;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W-1:0]      rounded;
  logic [SUM_W-1:0]      shifted;

  always_comb begin
    delta   = (target >= position) ? (target - position) : (position - target);
    prod    = PROD_W'(delta) * PROD_W'(scale);
    rounded = SUM_W'(prod) + (SUM_W'(1) << (SCALE_FRAC_BITS - 1));
    shifted = rounded >> SCALE_FRAC_BITS;
    steps   = (shifted > SUM_W'(STEP_MAX)) ? STEP_MAX : shifted[15:0];
  end

endmodule

@@ rtl/gms_sequencer.sv @@
// ----------------------------------------------------------------------------
// Gantry move sequencer state machine
// Holds the motion state and advances it by one item: X move, Y move, Z down,
// dwell, Z up, with limit back-off on X and Y.
// ----------------------------------------------------------------------------
module gms_sequencer import gms_pkg::*; #(
  parameter int COORD_BITS = 14
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  advance,
  input  logic                  item_op,
  input  logic [COORD_BITS-1:0] item_tx,
  input  logic [COORD_BITS-1:0] item_ty,
  input  logic                  item_xl,
  input  logic                  item_yl,
  input  gms_timing_t           timing,
  input  logic [15:0]           steps_x,
  input  logic [15:0]           steps_y,
  output logic [COORD_BITS-1:0] pos_x,
  output logic [COORD_BITS-1:0] pos_y,
  output gms_result_t           result
);

  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_X     = 3'd1;
  localparam logic [2:0] PH_Y     = 3'd2;
  localparam logic [2:0] PH_ZD    = 3'd3;
  localparam logic [2:0] PH_DWELL = 3'd4;
  localparam logic [2:0] PH_ZU    = 3'd5;
  localparam logic [2:0] PH_XB    = 3'd6;
  localparam logic [2:0] PH_YB    = 3'd7;

  logic [2:0]            ph_r,     ph_nxt;
  logic [COORD_BITS-1:0] pos_x_r,  pos_x_nxt;
  logic [COORD_BITS-1:0] pos_y_r,  pos_y_nxt;
  logic [COORD_BITS-1:0] goal_x_r, goal_x_nxt;
  logic [COORD_BITS-1:0] goal_y_r, goal_y_nxt;
  logic [15:0]           steps_r,  steps_nxt;
  logic [15:0]           syp_r,    syp_nxt;
  logic [15:0]           ht_r,     ht_nxt;
  logic [23:0]           dwell_r,  dwell_nxt;
  logic                  pulse_r,  pulse_nxt;
  logic [2:0]            dir_r,    dir_nxt;
  logic [1:0]            lim_r,    lim_nxt;
  logic [1:0]            zero_r,   zero_nxt;
  logic                  done_nxt;

  logic        go_x, go_bx, go_y, go_by, go_zd, go_dw, go_zu, go_fin;
  logic [15:0] ht_inc;
  logic [15:0] steps_dec;
  logic [23:0] dwell_dec;
  logic [15:0] backoff16;

  assign backoff16 = 16'(timing.backoff);

  always_comb begin
    ph_nxt     = ph_r;
    pos_x_nxt  = pos_x_r;
    pos_y_nxt  = pos_y_r;
    goal_x_nxt = goal_x_r;
    goal_y_nxt = goal_y_r;
    steps_nxt  = steps_r;
    syp_nxt    = syp_r;
    ht_nxt     = ht_r;
    dwell_nxt  = dwell_r;
    pulse_nxt  = pulse_r;
    dir_nxt    = dir_r;
    zero_nxt   = zero_r;
    lim_nxt    = lim_r | {item_yl, item_xl};
    done_nxt   = 1'b0;
    go_x = 1'b0; go_bx = 1'b0; go_y = 1'b0; go_by = 1'b0;
    go_zd = 1'b0; go_dw = 1'b0; go_zu = 1'b0; go_fin = 1'b0;
    ht_inc    = ht_r + 16'd1;
    steps_dec = (steps_r != 16'd0) ? (steps_r - 16'd1) : 16'd0;
    dwell_dec = (dwell_r != 24'd0) ? (dwell_r - 24'd1) : 24'd0;

    // A command is taken only while idle; otherwise the item is a tick.
    if (item_op && (ph_r == PH_IDLE)) begin
      goal_x_nxt = item_tx;
      goal_y_nxt = item_ty;
      zero_nxt   = 2'b00;
      dir_nxt    = {dir_r[2], (item_ty > pos_y_r), (item_tx > pos_x_r)};
      syp_nxt    = steps_y;
      go_x       = 1'b1;
    end else if (ph_r == PH_DWELL) begin
      dwell_nxt = dwell_dec;
      if (dwell_dec == 24'd0) go_zu = 1'b1;
    end else if (ph_r != PH_IDLE) begin
      if (ht_inc < timing.half_period) begin
        ht_nxt = ht_inc;
      end else begin
        ht_nxt = 16'd0;
        if (pulse_r) begin
          pulse_nxt = 1'b0;
        end else begin
          // End of a low half: one step is complete.
          steps_nxt = steps_dec;
          if (steps_dec == 16'd0) begin
            unique case (ph_r)
              PH_X:  go_y = 1'b1;
              PH_XB: begin
                lim_nxt[0] = 1'b0;
                go_y       = 1'b1;
              end
              PH_Y:  go_zd = 1'b1;
              PH_YB: begin
                lim_nxt[1] = 1'b0;
                go_zd      = 1'b1;
              end
              PH_ZD: go_dw = 1'b1;
              default: go_fin = 1'b1;
            endcase
          end else if (ph_r == PH_X) begin
            go_bx = 1'b1;
          end else if (ph_r == PH_Y) begin
            go_by = 1'b1;
          end else begin
            pulse_nxt = 1'b1;
          end
        end
      end
    end

    // Phase entries cascade forward within the same item when a count is zero.
    if (go_x) begin
      ph_nxt    = PH_X;
      steps_nxt = steps_x;
      ht_nxt    = 16'd0;
      pulse_nxt = (steps_x != 16'd0);
      if (steps_x == 16'd0) go_y = 1'b1;
      else go_bx = 1'b1;
    end
    if (go_bx) begin
      if (lim_nxt[0]) begin
        pos_x_nxt   = '0;
        zero_nxt[0] = 1'b1;
        dir_nxt[0]  = 1'b1;
        ph_nxt      = PH_XB;
        steps_nxt   = backoff16;
        ht_nxt      = 16'd0;
        pulse_nxt   = (backoff16 != 16'd0);
        if (backoff16 == 16'd0) begin
          lim_nxt[0] = 1'b0;
          go_y       = 1'b1;
        end
      end else begin
        pulse_nxt = 1'b1;
        ht_nxt    = 16'd0;
      end
    end
    if (go_y) begin
      ph_nxt    = PH_Y;
      steps_nxt = syp_nxt;
      ht_nxt    = 16'd0;
      pulse_nxt = (syp_nxt != 16'd0);
      if (syp_nxt == 16'd0) go_zd = 1'b1;
      else go_by = 1'b1;
    end
    if (go_by) begin
      if (lim_nxt[1]) begin
        pos_y_nxt   = '0;
        zero_nxt[1] = 1'b1;
        dir_nxt[1]  = 1'b1;
        ph_nxt      = PH_YB;
        steps_nxt   = backoff16;
        ht_nxt      = 16'd0;
        pulse_nxt   = (backoff16 != 16'd0);
        if (backoff16 == 16'd0) begin
          lim_nxt[1] = 1'b0;
          go_zd      = 1'b1;
        end
      end else begin
        pulse_nxt = 1'b1;
        ht_nxt    = 16'd0;
      end
    end
    if (go_zd) begin
      dir_nxt[2] = 1'b1;
      ph_nxt     = PH_ZD;
      steps_nxt  = timing.z_travel;
      ht_nxt     = 16'd0;
      pulse_nxt  = (timing.z_travel != 16'd0);
      if (timing.z_travel == 16'd0) go_dw = 1'b1;
    end
    if (go_dw) begin
      ph_nxt    = PH_DWELL;
      pulse_nxt = 1'b0;
      dwell_nxt = timing.dwell_ticks;
      if (timing.dwell_ticks == 24'd0) go_zu = 1'b1;
    end
    if (go_zu) begin
      dir_nxt[2] = 1'b0;
      ph_nxt     = PH_ZU;
      steps_nxt  = timing.z_travel;
      ht_nxt     = 16'd0;
      pulse_nxt  = (timing.z_travel != 16'd0);
      if (timing.z_travel == 16'd0) go_fin = 1'b1;
    end
    if (go_fin) begin
      // An axis that hit its limit stays at zero.
      pos_x_nxt = zero_nxt[0] ? '0 : goal_x_nxt;
      pos_y_nxt = zero_nxt[1] ? '0 : goal_y_nxt;
      ph_nxt    = PH_IDLE;
      pulse_nxt = 1'b0;
      ht_nxt    = 16'd0;
      done_nxt  = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r     <= PH_IDLE;
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      goal_x_r <= '0;
      goal_y_r <= '0;
      steps_r  <= '0;
      syp_r    <= '0;
      ht_r     <= '0;
      dwell_r  <= '0;
      pulse_r  <= 1'b0;
      dir_r    <= '0;
      lim_r    <= '0;
      zero_r   <= '0;
    end else if (advance) begin
      ph_r     <= ph_nxt;
      pos_x_r  <= pos_x_nxt;
      pos_y_r  <= pos_y_nxt;
      goal_x_r <= goal_x_nxt;
      goal_y_r <= goal_y_nxt;
      steps_r  <= steps_nxt;
      syp_r    <= syp_nxt;
      ht_r     <= ht_nxt;
      dwell_r  <= dwell_nxt;
      pulse_r  <= pulse_nxt;
      dir_r    <= dir_nxt;
      lim_r    <= lim_nxt;
      zero_r   <= zero_nxt;
    end
  end

  assign pos_x = pos_x_r;
  assign pos_y = pos_y_r;

  always_comb begin
    result.x_step    = ((ph_nxt == PH_X)  || (ph_nxt == PH_XB)) && pulse_nxt;
    result.x_dir     = dir_nxt[0];
    result.y_step    = ((ph_nxt == PH_Y)  || (ph_nxt == PH_YB)) && pulse_nxt;
    result.y_dir     = dir_nxt[1];
    result.z_step    = ((ph_nxt == PH_ZD) || (ph_nxt == PH_ZU)) && pulse_nxt;
    result.z_dir     = dir_nxt[2];
    result.heater_on = (ph_nxt == PH_DWELL);
    result.busy_res  = (ph_nxt != PH_IDLE);
    result.move_done = done_nxt;
  end

endmodule

@@ rtl/gantry_move_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// Gantry move sequencer
// Stepper sequencer for an X/Y/Z gantry with a dwell at each target point.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries one item per 1 us tick: either a plain tick
//   (op = 0) or a move command with a target X/Y (op = 1). A command is only
//   taken while the sequencer is idle; otherwise it counts as a tick. Limit
//   switch levels ride along on every item and are latched.
//   The result channel returns exactly one item per input item, showing the
//   step, direction, heater, busy and done lines after that item.
//   The accepting edge loads the input register; from there the step-count
//   multiply and the state update load the result register, which raises
//   out_valid. Throughput is one item per clock while the receiver does
//   not stall. When the receiver stalls, the result register holds, and
//   the input register takes one more item only if it is empty; in_ready
//   then stays low until out_ready. Reset (synchronous, active low)
//   returns the sequencer to idle at position zero and loads the default
//   settings. Settings must be written by the user through the cfg_ port
//   while no item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module gantry_move_sequencer_top import gms_pkg::*; #(
  parameter int COORD_BITS      = 14,
  parameter int SCALE_FRAC_BITS = 12
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [COORD_BITS-1:0] in_target_x,
  input  logic [COORD_BITS-1:0] in_target_y,
  input  logic                  in_x_limit,
  input  logic                  in_y_limit,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_x_step,
  output logic                  out_x_dir,
  output logic                  out_y_step,
  output logic                  out_y_dir,
  output logic                  out_z_step,
  output logic                  out_z_dir,
  output logic                  out_heater_on,
  output logic                  out_busy_res,
  output logic                  out_move_done
);

  gms_timing_t                timing;
  logic [SCALE_FRAC_BITS+1:0] x_scale;
  logic [SCALE_FRAC_BITS+1:0] y_scale;

  logic                  s1_valid_r, s1_valid_nxt;
  logic                  s1_op_r;
  logic [COORD_BITS-1:0] s1_tx_r;
  logic [COORD_BITS-1:0] s1_ty_r;
  logic                  s1_xl_r;
  logic                  s1_yl_r;
  logic                  out_valid_r, out_valid_nxt;
  gms_result_t           out_res_r;
  gms_result_t           seq_res;

  logic                  out_free;
  logic                  advance;
  logic                  in_take;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic [15:0]           steps_x;
  logic [15:0]           steps_y;

  gms_cfg_regs #(
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .timing    (timing),
    .x_scale   (x_scale),
    .y_scale   (y_scale)
  );

  gms_step_calc #(
    .COORD_BITS      (COORD_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_calc_x (
    .position (pos_x),
    .target   (s1_tx_r),
    .scale    (x_scale),
    .steps    (steps_x)
  );

  gms_step_calc #(
    .COORD_BITS      (COORD_BITS),
    .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
  ) u_calc_y (
    .position (pos_y),
    .target   (s1_ty_r),
    .scale    (y_scale),
    .steps    (steps_y)
  );

  gms_sequencer #(
    .COORD_BITS (COORD_BITS)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item_op (s1_op_r),
    .item_tx (s1_tx_r),
    .item_ty (s1_ty_r),
    .item_xl (s1_xl_r),
    .item_yl (s1_yl_r),
    .timing  (timing),
    .steps_x (steps_x),
    .steps_y (steps_y),
    .pos_x   (pos_x),
    .pos_y   (pos_y),
    .result  (seq_res)
  );

  // The registered item is processed whenever the result register can take it.
  assign out_free = !out_valid_r || out_ready;
  assign advance  = s1_valid_r && out_free;
  assign in_ready = !s1_valid_r || out_free;
  assign in_take  = in_valid && in_ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) s1_valid_nxt = 1'b1;
    else if (advance) s1_valid_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    if (advance) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op_r <= in_op;
      s1_tx_r <= in_target_x;
      s1_ty_r <= in_target_y;
      s1_xl_r <= in_x_limit;
      s1_yl_r <= in_y_limit;
    end
    if (advance) begin
      out_res_r <= seq_res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_x_step    = out_res_r.x_step;
  assign out_x_dir     = out_res_r.x_dir;
  assign out_y_step    = out_res_r.y_step;
  assign out_y_dir     = out_res_r.y_dir;
  assign out_z_step    = out_res_r.z_step;
  assign out_z_dir     = out_res_r.z_dir;
  assign out_heater_on = out_res_r.heater_on;
  assign out_busy_res  = out_res_r.busy_res;
  assign out_move_done = out_res_r.move_done;

endmodule

@@ rtl/gms_checker.sv @@
// ----------------------------------------------------------------------------
// Gantry move sequencer port checker
// Watches the result channel of the top level for consistency over time.
// ----------------------------------------------------------------------------
module gms_checker (
  input logic clk,
  input logic rst_n,
  input logic out_valid,
  input logic out_ready,
  input logic out_x_step,
  input logic out_x_dir,
  input logic out_y_step,
  input logic out_y_dir,
  input logic out_z_step,
  input logic out_z_dir,
  input logic out_heater_on,
  input logic out_busy_res,
  input logic out_move_done
);

  // A finished sequence leaves the sequencer idle on the same item.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_move_done) |-> !out_busy_res)
    else $error("move_done shown while still busy");

  // During the dwell no motor steps and the sequence is running.
  a_dwell_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_heater_on) |->
      (out_busy_res && !out_x_step && !out_y_step && !out_z_step))
    else $error("step pulse or idle during dwell");

  // Only one motor steps at a time, and only inside a sequence.
  a_one_motor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($countones({out_x_step, out_y_step, out_z_step}) <= 1) &&
      (!(out_x_step || out_y_step || out_z_step) || out_busy_res))
    else $error("more than one motor stepping, or stepping while idle");

  // A stalled result item holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid &&
      $stable({out_x_step, out_x_dir, out_y_step, out_y_dir, out_z_step,
               out_z_dir, out_heater_on, out_busy_res, out_move_done})))
    else $error("result item changed while stalled");

endmodule

bind gantry_move_sequencer_top gms_checker u_gms_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_x_step    (out_x_step),
  .out_x_dir     (out_x_dir),
  .out_y_step    (out_y_step),
  .out_y_dir     (out_y_dir),
  .out_z_step    (out_z_step),
  .out_z_dir     (out_z_dir),
  .out_heater_on (out_heater_on),
  .out_busy_res  (out_busy_res),
  .out_move_done (out_move_done)
);

@@ verif/tb_gantry_move_sequencer_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gantry move sequencer testbench
// Runs directed move sequences (default settings, zero-length moves, rounding,
// full travel, limit switches, back-pressure) and then random move sequences.
// A cycle-free predictor tracks the sequencer item by item, and every result
// item is compared with the prediction of the item that caused it.
// ----------------------------------------------------------------------------
module tb_gantry_move_sequencer_top;
  import gms_pkg::*;

  localparam int COORD_W = 14;
  localparam int FRAC_W  = 12;
  localparam int unsigned ITEM_TARGET = 1550;
  localparam logic [COORD_W-1:0] COORD_TOP = '1;
  localparam logic [13:0] SCALE_TOP = '1;
  localparam logic OP_TICK = 1'b0;
  localparam logic OP_MOVE = 1'b1;
  // Default scales in Q2.12, rounded from thousandths.
  localparam logic [13:0] X_SCALE_DEF = 14'((X_SCALE_MILLI * 4096 + 500) / 1000);
  localparam logic [13:0] Y_SCALE_DEF = 14'((Y_SCALE_MILLI * 4096 + 500) / 1000);

  typedef enum logic [2:0] {
    ST_IDLE, ST_XMOVE, ST_YMOVE, ST_ZDOWN, ST_DWELL, ST_ZUP, ST_XBACK, ST_YBACK
  } seq_state_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_op = 1'b0;
  logic [COORD_W-1:0] in_target_x = '0;
  logic [COORD_W-1:0] in_target_y = '0;
  logic in_x_limit = 1'b0;
  logic in_y_limit = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_x_step, out_x_dir, out_y_step, out_y_dir, out_z_step, out_z_dir;
  logic out_heater_on, out_busy_res, out_move_done;

  gantry_move_sequencer_top dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_op(in_op),
    .in_target_x(in_target_x), .in_target_y(in_target_y),
    .in_x_limit(in_x_limit), .in_y_limit(in_y_limit),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_x_step(out_x_step), .out_x_dir(out_x_dir),
    .out_y_step(out_y_step), .out_y_dir(out_y_dir),
    .out_z_step(out_z_step), .out_z_dir(out_z_dir),
    .out_heater_on(out_heater_on), .out_busy_res(out_busy_res),
    .out_move_done(out_move_done)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  // Predictor state and its copy of the settings.
  seq_state_e st;
  logic [COORD_W-1:0] pos_x, pos_y, goal_x, goal_y;
  logic [15:0] steps_left, y_steps_pend, half_cnt;
  logic [23:0] dwell_cnt;
  logic pulse, done_flag;
  logic [2:0] dirs;
  logic [1:0] lim_latch, zeroed;
  gms_timing_t tmg;
  logic [13:0] xs, ys;

  gms_result_t pending_results[$];
  int unsigned items_sent = 0;
  int unsigned err_count = 0;
  int unsigned results_seen = 0;
  bit tx_gaps_on = 1'b1;
  bit rx_gaps_on = 1'b1;
  int hold_req = 0;
  int hold_left = 0;
  int rx_gap_left = 0;

  function automatic void seq_reset();
    tmg.half_period = RST_STEP_HALF_PERIOD;
    tmg.z_travel = RST_Z_TRAVEL;
    tmg.dwell_ticks = RST_DWELL_TICKS;
    tmg.backoff = RST_BACKOFF_STEPS;
    xs = X_SCALE_DEF;
    ys = Y_SCALE_DEF;
    st = ST_IDLE;
    pos_x = '0; pos_y = '0; goal_x = '0; goal_y = '0;
    steps_left = '0; y_steps_pend = '0; half_cnt = '0; dwell_cnt = '0;
    pulse = 1'b0; done_flag = 1'b0; dirs = '0; lim_latch = '0; zeroed = '0;
  endfunction

  function automatic logic [15:0] step_count(logic [COORD_W-1:0] from, logic [COORD_W-1:0] to,
                                             logic [13:0] scale);
    logic [COORD_W-1:0] d;
    logic [31:0] p;
    d = (to >= from) ? to - from : from - to;
    p = (32'(d) * 32'(scale) + (32'd1 << (FRAC_W - 1))) >> FRAC_W;
    return (p > 32'(STEP_MAX)) ? STEP_MAX : p[15:0];
  endfunction

  function automatic void start_motion(seq_state_e s, logic [15:0] n);
    st = s;
    steps_left = n;
    half_cnt = '0;
    pulse = (n != 0);
  endfunction

  function automatic void close_sequence();
    pos_x = zeroed[0] ? '0 : goal_x;
    pos_y = zeroed[1] ? '0 : goal_y;
    st = ST_IDLE;
    pulse = 1'b0;
    half_cnt = '0;
    done_flag = 1'b1;
  endfunction

  function automatic void start_zup();
    dirs[2] = 1'b0;
    start_motion(ST_ZUP, tmg.z_travel);
    if (steps_left == 0) close_sequence();
  endfunction

  function automatic void start_dwell();
    st = ST_DWELL;
    pulse = 1'b0;
    dwell_cnt = tmg.dwell_ticks;
    if (dwell_cnt == 0) start_zup();
  endfunction

  function automatic void start_zdown();
    dirs[2] = 1'b1;
    start_motion(ST_ZDOWN, tmg.z_travel);
    if (steps_left == 0) start_dwell();
  endfunction

  // A latched switch is only looked at when a new X or Y step is due.
  function automatic void y_step_or_backoff();
    if (lim_latch[1]) begin
      pos_y = '0;
      zeroed[1] = 1'b1;
      dirs[1] = 1'b1;
      start_motion(ST_YBACK, 16'(tmg.backoff));
      if (steps_left == 0) begin
        lim_latch[1] = 1'b0;
        start_zdown();
      end
    end else begin
      pulse = 1'b1;
      half_cnt = '0;
    end
  endfunction

  function automatic void start_y_axis();
    start_motion(ST_YMOVE, y_steps_pend);
    if (steps_left == 0) start_zdown();
    else y_step_or_backoff();
  endfunction

  function automatic void x_step_or_backoff();
    if (lim_latch[0]) begin
      pos_x = '0;
      zeroed[0] = 1'b1;
      dirs[0] = 1'b1;
      start_motion(ST_XBACK, 16'(tmg.backoff));
      if (steps_left == 0) begin
        lim_latch[0] = 1'b0;
        start_y_axis();
      end
    end else begin
      pulse = 1'b1;
      half_cnt = '0;
    end
  endfunction

  function automatic void start_x_axis(logic [15:0] n);
    start_motion(ST_XMOVE, n);
    if (steps_left == 0) start_y_axis();
    else x_step_or_backoff();
  endfunction

  function automatic void axis_done();
    case (st)
      ST_XMOVE: start_y_axis();
      ST_XBACK: begin
        lim_latch[0] = 1'b0;
        start_y_axis();
      end
      ST_YMOVE: start_zdown();
      ST_YBACK: begin
        lim_latch[1] = 1'b0;
        start_zdown();
      end
      ST_ZDOWN: start_dwell();
      default: close_sequence();
    endcase
  endfunction

  function automatic void advance_tick();
    if (st == ST_IDLE) return;
    if (st == ST_DWELL) begin
      if (dwell_cnt > 0) dwell_cnt--;
      if (dwell_cnt == 0) start_zup();
      return;
    end
    half_cnt++;
    if (half_cnt < tmg.half_period) return;
    half_cnt = '0;
    if (pulse) begin
      pulse = 1'b0;
      return;
    end
    // A step ends with its low half.
    if (steps_left > 0) steps_left--;
    if (steps_left == 0) axis_done();
    else if (st == ST_XMOVE) x_step_or_backoff();
    else if (st == ST_YMOVE) y_step_or_backoff();
    else pulse = 1'b1;
  endfunction

  function automatic gms_result_t sequencer_predict(logic op, logic [COORD_W-1:0] tx,
                                                    logic [COORD_W-1:0] ty, logic xl, logic yl);
    gms_result_t r;
    logic [15:0] nx;
    done_flag = 1'b0;
    lim_latch |= {yl, xl};
    if (op == OP_MOVE && st == ST_IDLE) begin
      goal_x = tx;
      goal_y = ty;
      zeroed = '0;
      dirs[0] = (tx > pos_x);
      dirs[1] = (ty > pos_y);
      nx = step_count(pos_x, tx, xs);
      y_steps_pend = step_count(pos_y, ty, ys);
      start_x_axis(nx);
    end else begin
      advance_tick();
    end
    r.x_step = (st == ST_XMOVE || st == ST_XBACK) && pulse;
    r.x_dir = dirs[0];
    r.y_step = (st == ST_YMOVE || st == ST_YBACK) && pulse;
    r.y_dir = dirs[1];
    r.z_step = (st == ST_ZDOWN || st == ST_ZUP) && pulse;
    r.z_dir = dirs[2];
    r.heater_on = (st == ST_DWELL);
    r.busy_res = (st != ST_IDLE);
    r.move_done = done_flag;
    return r;
  endfunction

  // Mostly back-to-back, sometimes a few cycles, rarely a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("ERROR at %0t: %s", $time, msg);
  endtask

  // Receiver: random stalls, plus a long hold-off when a test asks for one.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (rx_gap_left != 0) begin
      rx_gap_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      rx_gap_left = rx_gaps_on ? pick_gap() : 0;
    end
  end

  always @(posedge clk) begin
    gms_result_t seen, want;
    if (rst_n && out_valid && out_ready) begin
      seen = {out_x_step, out_x_dir, out_y_step, out_y_dir, out_z_step, out_z_dir,
              out_heater_on, out_busy_res, out_move_done};
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no item pending", results_seen));
      end else begin
        want = pending_results.pop_front();
        if (seen !== want)
          report_mismatch($sformatf(
            "result %0d: got %09b expected %09b (xs xd ys yd zs zd heat busy done)",
            results_seen, seen, want));
      end
      results_seen++;
    end
  end

  task automatic send_item(input logic op, input logic [COORD_W-1:0] tx,
                           input logic [COORD_W-1:0] ty, input logic xl, input logic yl);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_target_x <= tx;
    in_target_y <= ty;
    in_x_limit <= xl;
    in_y_limit <= yl;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(sequencer_predict(op, tx, ty, xl, yl));
    items_sent++;
  endtask

  task automatic tick_item(input logic xl, input logic yl);
    send_item(OP_TICK, COORD_W'($urandom_range(0, 16383)), COORD_W'($urandom_range(0, 16383)),
              xl, yl);
  endtask

  task automatic run_to_idle();
    while (st != ST_IDLE) tick_item(1'b0, 1'b0);
  endtask

  // Stop offering items and wait until every result item has come back.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // Unused upper data bits carry junk; the registers must ignore them.
  task automatic program_settings(input logic [15:0] hp, input logic [13:0] xsc,
                                  input logic [13:0] ysc, input logic [15:0] zt,
                                  input logic [23:0] dw, input logic [7:0] bo);
    settle();
    write_reg(CFG_STEP_HALF_PERIOD, {8'($urandom), hp});
    write_reg(CFG_X_SCALE, {10'($urandom), xsc});
    write_reg(CFG_Y_SCALE, {10'($urandom), ysc});
    write_reg(CFG_Z_TRAVEL, {8'($urandom), zt});
    write_reg(CFG_DWELL_TICKS, dw);
    write_reg(CFG_BACKOFF_STEPS, {16'($urandom), bo});
    cfg_we <= 1'b0;
    tmg.half_period = hp;
    xs = xsc;
    ys = ysc;
    tmg.z_travel = zt;
    tmg.dwell_ticks = dw;
    tmg.backoff = bo;
  endtask

  // Start a move with the reset settings, then shorten the step period, Z and
  // the dwell mid-way.
  task automatic test_default_settings();
    send_item(OP_MOVE, 14'd3, 14'd2, 1'b0, 1'b0);
    repeat (40) tick_item(1'b0, 1'b0);
    send_item(OP_MOVE, 14'd100, 14'd100, 1'b0, 1'b0);
    program_settings(16'd1, X_SCALE_DEF, Y_SCALE_DEF, 16'd2, 24'd3, RST_BACKOFF_STEPS);
    run_to_idle();
  endtask

  task automatic test_zero_length_moves();
    program_settings(16'd1, SCALE_TOP, SCALE_TOP, 16'd0, 24'd0, 8'd0);
    send_item(OP_MOVE, pos_x, pos_y, 1'b0, 1'b0);
    send_item(OP_MOVE, pos_x, pos_y, 1'b0, 1'b0);
    program_settings(16'd1, 14'd0, 14'd0, 16'd0, 24'd0, 8'd0);
    send_item(OP_MOVE, COORD_TOP, COORD_TOP, 1'b0, 1'b0);
    send_item(OP_MOVE, 14'd0, 14'd0, 1'b0, 1'b0);
    program_settings(16'd1, 14'd0, 14'd0, 16'd1, 24'd1, 8'd0);
    send_item(OP_MOVE, 14'd0, 14'd0, 1'b0, 1'b0);
    run_to_idle();
  endtask

  task automatic test_half_period_zero();
    program_settings(16'd0, 14'd4096, 14'd4096, 16'd1, 24'd2, 8'd1);
    send_item(OP_MOVE, 14'd2, 14'd3, 1'b0, 1'b0);
    run_to_idle();
    program_settings(16'd2, 14'd4096, 14'd4096, 16'd1, 24'd1, 8'd1);
    send_item(OP_MOVE, 14'd1, 14'd0, 1'b0, 1'b0);
    run_to_idle();
  endtask

  // Scale 0.5 on one unit rounds up, just under 0.5 rounds down.
  task automatic test_rounding();
    program_settings(16'd1, 14'd0, 14'd0, 16'd0, 24'd0, 8'd0);
    send_item(OP_MOVE, 14'd0, 14'd0, 1'b0, 1'b0);
    program_settings(16'd1, 14'd2048, 14'd2047, 16'd0, 24'd0, 8'd0);
    send_item(OP_MOVE, 14'd1, 14'd1, 1'b0, 1'b0);
    run_to_idle();
    send_item(OP_MOVE, 14'd3, 14'd3, 1'b0, 1'b0);
    run_to_idle();
  endtask

  // Full travel at the smallest nonzero scale, then the largest scale over a
  // short distance; idling is off to keep the run short.
  task automatic test_full_travel();
    tx_gaps_on = 1'b0;
    rx_gaps_on = 1'b0;
    program_settings(16'd1, 14'd1, 14'd1, 16'd0, 24'd0, 8'd0);
    send_item(OP_MOVE, 14'd0, 14'd0, 1'b0, 1'b0);
    run_to_idle();
    send_item(OP_MOVE, COORD_TOP, COORD_TOP, 1'b0, 1'b0);
    run_to_idle();
    send_item(OP_MOVE, 14'd0, 14'd0, 1'b0, 1'b0);
    run_to_idle();
    program_settings(16'd1, SCALE_TOP, SCALE_TOP, 16'd0, 24'd0, 8'd0);
    send_item(OP_MOVE, 14'd5, 14'd5, 1'b0, 1'b0);
    run_to_idle();
    send_item(OP_MOVE, 14'd0, 14'd0, 1'b0, 1'b0);
    run_to_idle();
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  task automatic test_limit_switches();
    program_settings(16'd1, 14'd4096, 14'd4096, 16'd1, 24'd1, 8'd2);
    // Pressed while idle: stays pending until the first X step.
    tick_item(1'b1, 1'b0);
    send_item(OP_MOVE, 14'd3, 14'd3, 1'b0, 1'b0);
    run_to_idle();
    // No back-off steps: Y goes straight on to Z.
    program_settings(16'd1, 14'd4096, 14'd4096, 16'd1, 24'd1, 8'd0);
    tick_item(1'b0, 1'b1);
    send_item(OP_MOVE, 14'd5, 14'd5, 1'b0, 1'b0);
    run_to_idle();
    // Pressed during Z and the dwell: ignored there, taken on the next move.
    program_settings(16'd1, 14'd4096, 14'd4096, 16'd1, 24'd2, 8'd1);
    send_item(OP_MOVE, 14'd2, 14'd2, 1'b0, 1'b0);
    while (st != ST_IDLE) begin
      if (st == ST_ZDOWN || st == ST_DWELL) tick_item(1'b1, 1'b1);
      else tick_item(1'b0, 1'b0);
    end
    send_item(OP_MOVE, 14'd4, 14'd4, 1'b0, 1'b0);
    run_to_idle();
    // Pressed in the middle of the X move.
    send_item(OP_MOVE, 14'd6, 14'd6, 1'b0, 1'b0);
    repeat (3) tick_item(1'b0, 1'b0);
    tick_item(1'b1, 1'b0);
    run_to_idle();
    program_settings(16'd1, 14'd4096, 14'd4096, 16'd0, 24'd0, 8'd255);
    tick_item(1'b1, 1'b0);
    send_item(OP_MOVE, 14'd1, 14'd1, 1'b0, 1'b0);
    run_to_idle();
  endtask

  // Largest values of every register, with only idle ticks while they hold.
  task automatic test_extreme_settings();
    program_settings(16'hFFFF, SCALE_TOP, SCALE_TOP, 16'hFFFF, 24'hFFFFFF, 8'hFF);
    repeat (10) tick_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  task automatic test_backpressure();
    program_settings(16'd1, 14'd4096, 14'd4096, 16'd1, 24'd1, 8'd1);
    tx_gaps_on = 1'b0;
    hold_req = 300;
    send_item(OP_MOVE, 14'd9, 14'd2, 1'b0, 1'b0);
    repeat (60) tick_item(1'b0, 1'b0);
    tx_gaps_on = 1'b1;
    settle();
    run_to_idle();
  endtask

  function automatic logic [13:0] pick_scale();
    case ($urandom_range(0, 4))
      0: return 14'd0;
      1: return SCALE_TOP;
      2: return 14'd4096;
      3: return 14'($urandom_range(0, 64));
      default: return 14'($urandom_range(0, 16383));
    endcase
  endfunction

  function automatic logic [COORD_W-1:0] near_coord(logic [COORD_W-1:0] c);
    int v;
    v = int'(c) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > int'(COORD_TOP)) v = int'(COORD_TOP);
    return COORD_W'(v);
  endfunction

  // One move with random content, surrounded by noise: idle ticks,
  // commands while busy and stray limit switch presses.
  task automatic random_move();
    logic [COORD_W-1:0] tx, ty;
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 5)) tick_item($urandom_range(0, 19) == 0,
                                              $urandom_range(0, 19) == 0);
    tx = COORD_W'($urandom_range(0, 16383));
    ty = COORD_W'($urandom_range(0, 16383));
    if (step_count(pos_x, tx, xs) > 8) tx = near_coord(pos_x);
    if (step_count(pos_y, ty, ys) > 8) ty = near_coord(pos_y);
    send_item(OP_MOVE, tx, ty, $urandom_range(0, 15) == 0, $urandom_range(0, 15) == 0);
    while (st != ST_IDLE)
      send_item($urandom_range(0, 9) == 0 ? OP_MOVE : OP_TICK,
                COORD_W'($urandom_range(0, 16383)), COORD_W'($urandom_range(0, 16383)),
                $urandom_range(0, 39) == 0, $urandom_range(0, 39) == 0);
  endtask

  // Random batches fill up the item budget left over by the directed tests.
  task automatic test_random_moves();
    logic [15:0] hp;
    int r;
    while (items_sent < ITEM_TARGET) begin
      r = $urandom_range(0, 9);
      hp = (r < 7) ? 16'd1 : (r < 8) ? 16'd0 : 16'($urandom_range(2, 3));
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_gaps_on = ($urandom_range(0, 3) != 0);
      program_settings(hp, pick_scale(), pick_scale(), 16'($urandom_range(0, 3)),
                       ($urandom_range(0, 2) == 0) ? 24'd0 : 24'($urandom_range(1, 4)),
                       ($urandom_range(0, 19) == 0) ? 8'($urandom_range(4, 12)) :
                                                      8'($urandom_range(0, 3)));
      repeat ($urandom_range(3, 6)) random_move();
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  initial begin
    seq_reset();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_default_settings();
    test_zero_length_moves();
    test_half_period_zero();
    test_rounding();
    test_full_travel();
    test_limit_switches();
    test_extreme_settings();
    test_backpressure();
    test_random_moves();
    settle();
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ gantry_move_sequencer_top.f @@
rtl/gms_pkg.sv
rtl/gms_cfg_regs.sv
rtl/gms_step_calc.sv
rtl/gms_sequencer.sv
rtl/gantry_move_sequencer_top.sv
rtl/gms_checker.sv
verif/tb_gantry_move_sequencer_top.sv
